/* sv/sks_pkg.sv */
// Package for the servo keyframe stepper.
// Holds the word types, configuration codes, controller states and the initial pose.
// Depends on nothing; every other file of the block but sks_ram imports it.
package sks_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic       op;
    logic [5:0] frame;
    logic [3:0] joint;
    logic [9:0] target_pulse;
  } in_word_t;

  typedef struct packed {
    logic [3:0] joint_id;
    logic [9:0] pulse;
    logic       in_position;
    logic [5:0] frame_index;
    logic       last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic load_en;
    logic start;
    logic rd_en;
    logic rd_next;
    logic step_en;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic joint_last;
  } dp_status_t;

  function automatic logic [9:0] init_pose(input int idx);
    logic [9:0] val;
    case (idx)
      0: val = 10'd497;
      1: val = 10'd500;
      2: val = 10'd399;
      3: val = 10'd600;
      4: val = 10'd500;
      5: val = 10'd500;
      6: val = 10'd613;
      7: val = 10'd388;
      8: val = 10'd504;
      9: val = 10'd497;
      default: val = 10'd500;
    endcase
    return val;
  endfunction

endpackage

/* sv/sks_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the keyframe table; depends on nothing.
module sks_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 640
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/sks_ctrl.sv */
// Controller of the servo keyframe stepper: sequences loads and ticks.
// Depends on sks_pkg for the state type and the command and status structs.
module sks_ctrl
  import sks_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_op,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_TICK) begin
            cmd.start = 1'b1;
            state_nxt = ST_FETCH;
          end else begin
            cmd.load_en = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (status.slot_free) begin
          cmd.step_en = 1'b1;
          if (status.joint_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/sks_dp.sv */
// Datapath of the servo keyframe stepper: configuration, joint state, step unit,
// keyframe table and output register. Depends on sks_pkg and sks_ram.
module sks_dp
  import sks_pkg::*;
#(
  parameter int MAX_FRAMES = 64,
  parameter int JOINTS     = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  in_word_t              in_data,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data
);

  localparam int FR_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int JW     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int DEPTH  = MAX_FRAMES * JOINTS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW     = AW + 7;
  localparam int CNT_C  = $clog2(MAX_FRAMES + 1);
  localparam int CNT_W  = (CNT_C > 7) ? CNT_C : 7;

  logic [6:0]        frame_count_r;
  logic [9:0]        step_size_r;
  logic [FR_W-1:0]   cf_r;
  logic [JW-1:0]     j_r;
  logic [9:0]        pos_r [JOINTS];
  logic [JOINTS-1:0] flag_r;
  logic              out_valid_r;
  out_word_t         out_r;

  logic [9:0]        step_eff;
  logic [CNT_W-1:0]  fc_ext;
  logic [CNT_W-1:0]  fc_use;
  logic [CNT_W-1:0]  cf_inc;
  logic [FR_W-1:0]   cf_adv;
  logic [9:0]        pos_cur;
  logic [9:0]        tgt;
  logic [10:0]       sum_up;
  logic [10:0]       sum_tg;
  logic              move_up;
  logic              move_dn;
  logic [9:0]        pos_nxt;
  logic [JOINTS-1:0] flag_nxt;
  logic              all_reached;
  logic              j_last;
  logic [JW-1:0]     j_rd;
  logic [AW-1:0]     raddr;
  logic [WW-1:0]     waddr_wide;
  logic              load_ok;
  out_word_t         out_nxt;

  always_comb begin
    step_eff = (step_size_r == 10'd0) ? 10'd1 : step_size_r;
    fc_ext   = CNT_W'(frame_count_r);
    if (fc_ext == '0) begin
      fc_use = CNT_W'(1);
    end else if (fc_ext > CNT_W'(MAX_FRAMES)) begin
      fc_use = CNT_W'(MAX_FRAMES);
    end else begin
      fc_use = fc_ext;
    end
    cf_inc = CNT_W'(cf_r) + CNT_W'(1);
    cf_adv = (cf_inc >= fc_use) ? '0 : FR_W'(cf_inc);

    pos_cur = pos_r[j_r];
    sum_up  = {1'b0, pos_cur} + {1'b0, step_eff};
    sum_tg  = {1'b0, tgt} + {1'b0, step_eff};
    move_up = sum_up < {1'b0, tgt};
    move_dn = {1'b0, pos_cur} > sum_tg;
    if (move_up) begin
      pos_nxt = pos_cur + step_eff;
    end else if (move_dn) begin
      pos_nxt = pos_cur - step_eff;
    end else begin
      pos_nxt = pos_cur;
    end
    flag_nxt      = flag_r;
    flag_nxt[j_r] = flag_r[j_r] | (!move_up && !move_dn);
    all_reached   = &flag_nxt;
    j_last        = (j_r == JW'(JOINTS - 1));

    out_nxt             = '0;
    out_nxt.joint_id    = 4'(j_r);
    out_nxt.pulse       = pos_cur;
    if (j_last) begin
      out_nxt.last        = 1'b1;
      out_nxt.in_position = all_reached;
      out_nxt.frame_index = all_reached ? 6'(cf_adv) : 6'(cf_r);
    end
  end

  assign j_rd       = cmd.rd_next ? JW'(j_r + 1'b1) : j_r;
  assign raddr      = AW'(cf_r) * AW'(JOINTS) + AW'(j_rd);
  assign waddr_wide = WW'(in_data.frame) * WW'(JOINTS) + WW'(in_data.joint);
  assign load_ok    = cmd.load_en && (int'(in_data.frame) < MAX_FRAMES)
                      && (int'(in_data.joint) < JOINTS);

  sks_ram #(
    .WIDTH (10),
    .DEPTH (DEPTH)
  ) u_frames (
    .clk   (clk),
    .we    (load_ok),
    .waddr (AW'(waddr_wide)),
    .wdata (in_data.target_pulse),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (tgt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= 7'd1;
      step_size_r   <= 10'd1;
      cf_r          <= '0;
      j_r           <= '0;
      flag_r        <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < JOINTS; i++) begin
        pos_r[i] <= init_pose(i);
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FRAME_COUNT: frame_count_r <= cfg_data[6:0];
          CFG_STEP_SIZE:   step_size_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.start) begin
        j_r <= '0;
      end
      if (cmd.step_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.step_en) begin
        pos_r[j_r] <= pos_nxt;
        if (j_last) begin
          if (all_reached) begin
            flag_r <= '0;
            cf_r   <= cf_adv;
          end else begin
            flag_r <= flag_nxt;
          end
        end else begin
          flag_r <= flag_nxt;
          j_r    <= j_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_en) begin
      out_r <= out_nxt;
    end
  end

  assign status.slot_free  = !out_valid_r || out_ready;
  assign status.joint_last = j_last;
  assign out_valid         = out_valid_r;
  assign out_data          = out_r;

endmodule

/* sv/servo_keyframe_stepper.sv */
// Top level of the servo keyframe stepper: joins the controller and the datapath.
// Depends on sks_pkg, sks_ctrl and sks_dp.
//
// A load word writes one keyframe entry if its frame and joint are in range. A tick word
// is accepted, then the first keyframe entry is read, then the joints are stepped at one
// per cycle while the output is not stalled: the joints pass one at a time through
// a single step unit fed by the one read port of the keyframe memory, and each
// joint leaves one result word through a registered output stage. A stalled
// output holds the sequence at the current joint. The keyframe table has no reset.
module servo_keyframe_stepper
  import sks_pkg::*;
#(
  parameter int MAX_FRAMES = 64,
  parameter int JOINTS     = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  sks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sks_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .JOINTS     (JOINTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/sks_motion_checker.sv */
// Checker for the servo keyframe stepper: keeps its own copy of the gait state, predicts the
// result words of every tick word and compares them with what leaves the block.
// Depends on sks_pkg for the word types and the register and operation codes.
module sks_motion_checker
  import sks_pkg::*;
#(
  parameter int MAX_FRAMES = 64,
  parameter int JOINTS     = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_word_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    reports_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [9:0] HOME_POSE [10] = '{10'd497, 10'd500, 10'd399, 10'd600, 10'd500,
                                            10'd500, 10'd613, 10'd388, 10'd504, 10'd497};

  logic [9:0] pose [JOINTS];
  logic       reached [JOINTS];
  logic [5:0] gait_frame;
  logic [9:0] keyframes [MAX_FRAMES*JOINTS];
  logic [6:0] frame_count_reg;
  logic [9:0] step_size_reg;
  out_word_t  expected_reports[$];

  function automatic logic [9:0] home_of(input int j);
    return (j < 10) ? HOME_POSE[j] : 10'd500;
  endfunction

  // Reports every joint as it stood, then steps each one toward the current row.
  task automatic advance_gait();
    out_word_t batch [JOINTS];
    int        stride;
    int        now;
    int        goal;
    int        used;
    logic      all_reached;
    stride = (step_size_reg == 10'd0) ? 1 : int'(step_size_reg);
    all_reached = 1'b1;
    for (int i = 0; i < JOINTS; i++) begin
      batch[i] = '0;
      batch[i].joint_id = i[3:0];
      batch[i].pulse = pose[i];
      now = int'(pose[i]);
      goal = int'(keyframes[int'(gait_frame)*JOINTS + i]);
      if (now < goal - stride) begin
        now = now + stride;
      end else if (now > goal + stride) begin
        now = now - stride;
      end else begin
        reached[i] = 1'b1;
      end
      pose[i] = now[9:0];
      all_reached = all_reached & reached[i];
    end
    if (all_reached) begin
      if (frame_count_reg == 7'd0) begin
        used = 1;
      end else if (int'(frame_count_reg) > MAX_FRAMES) begin
        used = MAX_FRAMES;
      end else begin
        used = int'(frame_count_reg);
      end
      if (int'(gait_frame) + 1 >= used) begin
        gait_frame = '0;
      end else begin
        gait_frame = gait_frame + 6'd1;
      end
      for (int i = 0; i < JOINTS; i++) begin
        reached[i] = 1'b0;
      end
    end
    batch[JOINTS-1].in_position = all_reached;
    batch[JOINTS-1].frame_index = gait_frame;
    batch[JOINTS-1].last = 1'b1;
    for (int i = 0; i < JOINTS; i++) begin
      expected_reports.push_back(batch[i]);
    end
  endtask

  function automatic int field_differs(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < JOINTS; i++) begin
        pose[i] = home_of(i);
        reached[i] = 1'b0;
      end
      gait_frame = '0;
      frame_count_reg = 7'd1;
      step_size_reg = 10'd1;
      mismatch_count = 0;
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("result word with no prediction: joint_id %0d, pulse %0d",
                 out_data.joint_id, out_data.pulse);
          mismatch_count++;
        end else begin
          automatic out_word_t want = expected_reports.pop_front();
          automatic int bad = 0;
          bad += field_differs("joint_id", want.joint_id, out_data.joint_id);
          bad += field_differs("pulse", want.pulse, out_data.pulse);
          bad += field_differs("in_position", want.in_position, out_data.in_position);
          bad += field_differs("frame_index", want.frame_index, out_data.frame_index);
          bad += field_differs("last", want.last, out_data.last);
          if (bad != 0) begin
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_COUNT: frame_count_reg = cfg_data[6:0];
          CFG_STEP_SIZE:   step_size_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.op == OP_TICK) begin
          advance_gait();
        end else if (int'(in_data.frame) < MAX_FRAMES && int'(in_data.joint) < JOINTS) begin
          keyframes[int'(in_data.frame)*JOINTS + int'(in_data.joint)] = in_data.target_pulse;
        end
      end
    end
    reports_pending = expected_reports.size();
  end

endmodule

/* tb/sv/servo_keyframe_stepper_tb.sv */
// Testbench top for the servo keyframe stepper: drives load, tick and register words with
// random gaps and output stalls, and gives the verdict from the checker's counts.
// Depends on sks_pkg, servo_keyframe_stepper and sks_motion_checker.
module servo_keyframe_stepper_tb
  import sks_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAMES = 64;
  localparam int JOINTS     = 10;
  localparam int PHASES     = 11;
  localparam int PHASE_ITEMS = 9;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatch_count;
  int                    reports_pending;

  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;
  int         rows_ready = 0;
  logic [6:0] fc_now = 7'd1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  servo_keyframe_stepper #(
    .MAX_FRAMES(MAX_FRAMES),
    .JOINTS    (JOINTS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  sks_motion_checker #(
    .MAX_FRAMES(MAX_FRAMES),
    .JOINTS    (JOINTS)
  ) u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .reports_pending(reports_pending)
  );

  function automatic int frames_active();
    if (fc_now == 7'd0) return 1;
    if (int'(fc_now) > MAX_FRAMES) return MAX_FRAMES;
    return int'(fc_now);
  endfunction

  // Valid is left high on return so that a word with no gap follows without a drop.
  task automatic push_word(input in_word_t w);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_load(input logic [5:0] row, input logic [3:0] col,
                           input logic [9:0] pulse);
    in_word_t w;
    w.op = OP_LOAD;
    w.frame = row;
    w.joint = col;
    w.target_pulse = pulse;
    push_word(w);
  endtask

  // A tick can move the gait at most one row on, so the next unwritten row is filled first
  // whenever the frames in use reach past what has been written.
  task automatic push_tick();
    in_word_t w;
    if (frames_active() > rows_ready) begin
      for (int j = 0; j < JOINTS; j++) begin
        push_load(rows_ready[5:0], j[3:0], 10'($urandom_range(0, 1023)));
      end
      rows_ready++;
    end
    w = $bits(in_word_t)'($urandom);
    w.op = OP_TICK;
    push_word(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Registers change only once the block has drained and a trailing load has had time to land.
  task automatic settle_and_configure(input logic [9:0] fc, input logic [9:0] ss);
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_pending != 0);
    repeat (JOINTS + 4) @(posedge clk);
    write_reg(CFG_FRAME_COUNT, fc);
    write_reg(CFG_STEP_SIZE, ss);
    cfg_valid <= 1'b0;
    fc_now = fc[6:0];
  endtask

  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [9:0] first_row [JOINTS];
    logic [9:0] fc_list [PHASES];
    logic [9:0] ss_list [PHASES];
    first_row = '{10'd0, 10'd1023, 10'd399, 10'd600, 10'd500,
                  10'd500, 10'd613, 10'd388, 10'd504, 10'd497};
    fc_list = '{10'd2, 10'd127, 10'd2, 10'h3C2, 10'd0, 10'd5,
                10'd1, 10'd20, 10'd3, 10'd64, 10'd1};
    ss_list = '{10'd1023, 10'd1023, 10'd300, 10'd512, 10'd0, 10'd64,
                10'd1, 10'd900, 10'd200, 10'd1023, 10'd1000};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Row zero holds both pulse extremes; out-of-range joints must be ignored.
    for (int j = 0; j < JOINTS; j++) begin
      push_load(6'd0, j[3:0], first_row[j]);
    end
    rows_ready = 1;
    push_load(6'd63, 4'd10, 10'd1023);
    push_load(6'd42, 4'd15, 10'd0);
    push_tick();
    push_tick();
    // A zero frame count and a zero step both behave as one.
    settle_and_configure(10'd0, 10'd0);
    push_tick();
    push_tick();
    // A full-scale step reaches every target at once, so the single frame wraps each tick.
    settle_and_configure(10'd1, 10'd1023);
    repeat (3) push_tick();

    for (int p = 0; p < PHASES; p++) begin
      settle_and_configure(fc_list[p], ss_list[p]);
      tx_calm = (p % 4 == 1);
      rx_calm = (p % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          push_load(6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                    10'($urandom_range(0, 1023)));
        end else begin
          push_tick();
        end
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (reports_pending != 0);
    repeat (JOINTS + 4) @(posedge clk);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
sv/sks_pkg.sv
sv/sks_ram.sv
sv/sks_ctrl.sv
sv/sks_dp.sv
sv/servo_keyframe_stepper.sv
tb/sv/sks_motion_checker.sv
tb/sv/servo_keyframe_stepper_tb.sv
